### rtl/rrps_pkg.sv
// shared types and constants of the round-robin process scheduler
`default_nettype none

package rrps_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int ID_W    = 8;
   localparam int BURST_W = 16;
   localparam int TICK_W  = 16;
   localparam int QUANT_W = 8;

   localparam logic REQ_ARRIVAL = 1'b0;
   localparam logic REQ_TICK    = 1'b1;

   localparam logic [QUANT_W-1:0] QUANTUM_RESET = QUANT_W'(1);

   typedef logic [PTR_W-1:0]   ptr_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [ID_W-1:0]    id_type;
   typedef logic [BURST_W-1:0] burst_type;

   typedef struct packed {
      logic      req_type;
      id_type    proc_id;
      burst_type burst_time;
   } req_item_type;

   // queue update requested by the scheduler for one cycle
   typedef struct packed {
      logic      push;
      logic      pop;
      logic      dec_head;
      logic      rotate;
      id_type    wr_id;
      burst_type wr_rem;
   } queue_cmd_type;

   typedef struct packed {
      logic      empty;
      logic      full;
      id_type    head_id;
      burst_type head_rem;
   } queue_stat_type;

   function automatic ptr_type next_slot(input ptr_type p);
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

endpackage

`default_nettype wire

### rtl/rrps_channels.sv
// valid/ready channel interfaces for requests and responses
`default_nettype none

interface rrps_req_if;
   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic [rrps_pkg::ID_W-1:0]    proc_id;
   logic [rrps_pkg::BURST_W-1:0] burst_time;

   modport source (output valid, output req_type, output proc_id, output burst_time,
                   input ready);
   modport sink (input valid, input req_type, input proc_id, input burst_time,
                 output ready);
endinterface

interface rrps_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [rrps_pkg::TICK_W-1:0] tick_time;
   logic [rrps_pkg::ID_W-1:0]   run_id;
   logic                      idle;
   logic                      finished;
   logic                      dropped;

   modport source (output valid, output tick_time, output run_id, output idle,
                   output finished, output dropped, input ready);
   modport sink (input valid, input tick_time, input run_id, input idle,
                 input finished, input dropped, output ready);
endinterface

`default_nettype wire

### rtl/rrps_in_reg.sv
// input register stage holding one accepted request
`default_nettype none

module rrps_in_reg (
   input  wire logic               clock,
   input  wire logic               reset,
   rrps_req_if.sink                req_chan,
   input  wire logic               take,
   output rrps_pkg::req_item_type  item,
   output logic                    item_valid
);

   logic                   valid_ff, valid_in;
   rrps_pkg::req_item_type item_ff;

   assign req_chan.ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      if (req_chan.ready) begin
         valid_in = req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         item_ff.req_type   <= req_chan.req_type;
         item_ff.proc_id    <= req_chan.proc_id;
         item_ff.burst_time <= req_chan.burst_time;
      end
   end

   assign item       = item_ff;
   assign item_valid = valid_ff;

endmodule

`default_nettype wire

### rtl/rrps_queue.sv
// circular ready queue of process ids and remaining burst times
`default_nettype none

module rrps_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire rrps_pkg::queue_cmd_type cmd,
   output rrps_pkg::queue_stat_type stat
);

   rrps_pkg::id_type    ids_ff [rrps_pkg::QUEUE_DEPTH];
   rrps_pkg::burst_type rem_ff [rrps_pkg::QUEUE_DEPTH];

   rrps_pkg::ptr_type head_ff, head_in;
   rrps_pkg::ptr_type tail_ff, tail_in;
   rrps_pkg::cnt_type count_ff, count_in;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (cmd.push) begin
         tail_in  = rrps_pkg::next_slot(tail_ff);
         count_in = count_ff + rrps_pkg::CNT_W'(1);
      end
      if (cmd.pop) begin
         head_in  = rrps_pkg::next_slot(head_ff);
         count_in = count_ff - rrps_pkg::CNT_W'(1);
      end
      // rotation copies the head entry to the tail, count unchanged
      if (cmd.rotate) begin
         head_in = rrps_pkg::next_slot(head_ff);
         tail_in = rrps_pkg::next_slot(tail_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push || cmd.rotate) begin
         ids_ff[tail_ff] <= cmd.wr_id;
         rem_ff[tail_ff] <= cmd.wr_rem;
      end else if (cmd.dec_head) begin
         rem_ff[head_ff] <= cmd.wr_rem;
      end
   end

   assign stat.empty    = (count_ff == '0);
   assign stat.full     = (count_ff == rrps_pkg::CNT_W'(rrps_pkg::QUEUE_DEPTH));
   assign stat.head_id  = ids_ff[head_ff];
   assign stat.head_rem = rem_ff[head_ff];

endmodule

`default_nettype wire

### rtl/round_robin_process_scheduler_unit.sv
// Round-robin process scheduler: a 16-entry ready queue driven by arrival and
// tick requests. An arrival appends a process (or, with the queue full, gives a
// dropped response); a tick runs the head process for one time unit and gives
// a response with the tick number, the process id and the idle/finished flags.
// One request is taken every cycle while the response register can accept the
// response it needs; a request passes an input register, then the queue update
// and response are decided combinationally into the response register. The
// rate is set by the read-modify-write of the queue head entry.
// Write csr_wr_data (quantum, 0 acts as 1) only while no request is in flight.
`default_nettype none

module round_robin_process_scheduler_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   rrps_req_if.sink                           req_chan,
   rrps_rsp_if.source                         rsp_chan,
   input  wire logic                          csr_wr_en,
   input  wire logic [rrps_pkg::QUANT_W-1:0]  csr_wr_data
);

   rrps_pkg::req_item_type   item;
   logic                     item_valid;
   logic                     take;
   rrps_pkg::queue_cmd_type  cmd;
   rrps_pkg::queue_stat_type stat;

   logic [rrps_pkg::QUANT_W-1:0] quantum_ff;
   logic [rrps_pkg::QUANT_W-1:0] quantum_eff;
   logic [rrps_pkg::QUANT_W-1:0] slice_ff, slice_in, slice_next;
   logic [rrps_pkg::TICK_W-1:0]  tick_ff, tick_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [rrps_pkg::TICK_W-1:0]  tick_time_ff, tick_time_in;
   rrps_pkg::id_type             run_id_ff, run_id_in;
   logic                         idle_ff, idle_in;
   logic                         finished_ff, finished_in;
   logic                         dropped_ff, dropped_in;

   logic is_tick, need_rsp, out_free;

   rrps_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .take       (take),
      .item       (item),
      .item_valid (item_valid)
   );

   rrps_queue u_queue (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   assign is_tick  = (item.req_type == rrps_pkg::REQ_TICK);
   assign need_rsp = is_tick || stat.full;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign take     = item_valid && (!need_rsp || out_free);

   assign quantum_eff = (quantum_ff == '0) ? rrps_pkg::QUANT_W'(1) : quantum_ff;
   assign slice_next  = slice_ff + rrps_pkg::QUANT_W'(1);

   always_comb begin
      cmd          = '0;
      cmd.wr_id    = item.proc_id;
      cmd.wr_rem   = item.burst_time;
      slice_in     = slice_ff;
      tick_in      = tick_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      tick_time_in = tick_time_ff;
      run_id_in    = run_id_ff;
      idle_in      = idle_ff;
      finished_in  = finished_ff;
      dropped_in   = dropped_ff;
      if (take) begin
         if (need_rsp) begin
            rsp_valid_in = 1'b1;
            tick_time_in = tick_ff;
            run_id_in    = stat.head_id;
            idle_in      = 1'b0;
            finished_in  = 1'b0;
            dropped_in   = 1'b0;
         end
         if (!is_tick) begin
            if (stat.full) begin
               run_id_in  = item.proc_id;
               dropped_in = 1'b1;
            end else begin
               cmd.push = 1'b1;
            end
         end else begin
            tick_in = tick_ff + rrps_pkg::TICK_W'(1);
            if (stat.empty) begin
               run_id_in = '0;
               idle_in   = 1'b1;
            end else if (stat.head_rem <= rrps_pkg::BURST_W'(1)) begin
               cmd.pop     = 1'b1;
               slice_in    = '0;
               finished_in = 1'b1;
            end else begin
               cmd.wr_id  = stat.head_id;
               cmd.wr_rem = stat.head_rem - rrps_pkg::BURST_W'(1);
               // slice used up: move the process to the tail
               if (slice_next >= quantum_eff) begin
                  cmd.rotate = 1'b1;
                  slice_in   = '0;
               end else begin
                  cmd.dec_head = 1'b1;
                  slice_in     = slice_next;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff   <= rrps_pkg::QUANTUM_RESET;
         slice_ff     <= '0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            quantum_ff <= csr_wr_data;
         end
         slice_ff     <= slice_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tick_time_ff <= tick_time_in;
      run_id_ff    <= run_id_in;
      idle_ff      <= idle_in;
      finished_ff  <= finished_in;
      dropped_ff   <= dropped_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.tick_time = tick_time_ff;
   assign rsp_chan.run_id    = run_id_ff;
   assign rsp_chan.idle      = idle_ff;
   assign rsp_chan.finished  = finished_ff;
   assign rsp_chan.dropped   = dropped_ff;

endmodule

`default_nettype wire

### bench/tb.sv
// testbench of the round-robin process scheduler: directed and random requests
module tb;
   import rrps_pkg::*;

   localparam int LIMIT_CYCLES  = 200_000;
   localparam int MAX_GAP       = 11;
   localparam int SETTLE_CYCLES = 6;
   localparam int MAX_PRINTS    = 50;

   typedef struct {
      logic [TICK_W-1:0] tick_time;
      id_type            run_id;
      logic              idle;
      logic              finished;
      logic              dropped;
   } slot_report_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en;
   logic [QUANT_W-1:0] csr_wr_data;

   rrps_req_if req_if ();
   rrps_rsp_if rsp_if ();

   round_robin_process_scheduler_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // ready queue as the bench tracks it
   id_type             ready_ids_m  [QUEUE_DEPTH];
   burst_type          ready_left_m [QUEUE_DEPTH];
   int                 q_head;
   int                 q_tail;
   int                 q_count;
   logic [7:0]         slice_ticks;
   logic [TICK_W-1:0]  tick_now;
   logic [QUANT_W-1:0] quantum_now;

   slot_report_type pending_reports [$];
   int              err_count   = 0;
   int              cycle_count = 0;
   bit              gaps_on     = 1'b1;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic int draw_gap();
      if (!gaps_on) begin
         return 0;
      end
      return $urandom_range(0, MAX_GAP);
   endfunction

   function automatic int next_pos(input int p);
      return (p + 1) % QUEUE_DEPTH;
   endfunction

   // advance the queue model by one accepted request, queue the response it causes
   function automatic void schedule_step(input logic kind, input id_type id,
                                         input burst_type burst);
      slot_report_type rep;
      int              eff_q;
      burst_type       left;
      rep = '{tick_time: tick_now, run_id: id, idle: 1'b0, finished: 1'b0, dropped: 1'b0};
      if (kind == REQ_ARRIVAL) begin
         if (q_count >= QUEUE_DEPTH) begin
            rep.dropped = 1'b1;
            pending_reports.push_back(rep);
         end else begin
            ready_ids_m[q_tail]  = id;
            ready_left_m[q_tail] = burst;
            q_tail  = next_pos(q_tail);
            q_count = q_count + 1;
         end
         return;
      end
      tick_now = tick_now + 1'b1;
      if (q_count == 0) begin
         rep.run_id = '0;
         rep.idle   = 1'b1;
         pending_reports.push_back(rep);
         return;
      end
      rep.run_id = ready_ids_m[q_head];
      left       = ready_left_m[q_head];
      eff_q      = (quantum_now == '0) ? 1 : int'(quantum_now);
      if (left <= 1) begin
         q_head       = next_pos(q_head);
         q_count      = q_count - 1;
         slice_ticks  = '0;
         rep.finished = 1'b1;
      end else begin
         ready_left_m[q_head] = left - 1'b1;
         slice_ticks = slice_ticks + 1'b1;
         if (slice_ticks >= eff_q) begin
            // slice used up: copy the head entry to the tail
            ready_ids_m[q_tail]  = rep.run_id;
            ready_left_m[q_tail] = left - 1'b1;
            q_head      = next_pos(q_head);
            q_tail      = next_pos(q_tail);
            slice_ticks = '0;
         end
      end
      pending_reports.push_back(rep);
   endfunction

   task automatic report_mismatch(input string msg);
      err_count = err_count + 1;
      if (err_count <= MAX_PRINTS) begin
         $display("cycle %0d: %s", cycle_count, msg);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
      end
   endtask

   task automatic send_req(input logic kind, input id_type id, input burst_type burst);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.req_type   <= kind;
      req_if.proc_id    <= id;
      req_if.burst_time <= burst;
      do @(posedge clock); while (!req_if.ready);
      schedule_step(kind, id, burst);
   endtask

   task automatic send_tick();
      // payload is don't-care on a tick, so keep it moving
      send_req(REQ_TICK, id_type'($urandom), burst_type'($urandom));
   endtask

   task automatic drain_and_settle();
      req_if.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      // arrivals give no response and may still be in the pipeline
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_quantum(input logic [QUANT_W-1:0] q);
      drain_and_settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= q;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      quantum_now = q;
   endtask

   // response side: random stalls, every transfer compared with the oldest expectation
   initial begin : result_monitor
      int              hold;
      slot_report_type want;
      hold = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (pending_reports.size() == 0) begin
               report_mismatch($sformatf("unexpected response tick %0d id %0h",
                                         rsp_if.tick_time, rsp_if.run_id));
            end else begin
               want = pending_reports.pop_front();
               check_field("tick_time", rsp_if.tick_time, want.tick_time);
               check_field("run_id", rsp_if.run_id, want.run_id);
               check_field("idle", rsp_if.idle, want.idle);
               check_field("finished", rsp_if.finished, want.finished);
               check_field("dropped", rsp_if.dropped, want.dropped);
            end
            hold = draw_gap();
         end
         if (reset || hold > 0) begin
            rsp_if.ready <= 1'b0;
            if (hold > 0) begin
               hold = hold - 1;
            end
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic test_extreme_fields();
      send_tick();
      send_req(REQ_ARRIVAL, 8'h00, 16'd1);
      send_req(REQ_ARRIVAL, 8'hFF, 16'hFFFF);
      // zero burst time finishes on its first tick
      send_req(REQ_ARRIVAL, 8'hA5, 16'd0);
      // last two ticks rotate a lone process onto itself
      repeat (5) send_tick();
   endtask

   task automatic test_full_queue();
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
         send_req(REQ_ARRIVAL, id_type'(i * 17), 16'd2);
      end
      send_req(REQ_ARRIVAL, 8'h3C, 16'd9);
      while (q_count > 1) send_tick();
   endtask

   task automatic test_quantum_zero();
      write_quantum('0);
      send_req(REQ_ARRIVAL, 8'h42, 16'd3);
      repeat (4) send_tick();
   endtask

   task automatic test_quantum_lowered();
      write_quantum(8'd5);
      send_req(REQ_ARRIVAL, 8'h07, 16'd30);
      repeat (3) send_tick();
      // slice already past the new quantum: rotates on the next tick
      write_quantum(8'd2);
      repeat (2) send_tick();
   endtask

   function automatic burst_type draw_burst();
      int r;
      r = $urandom_range(0, 199);
      if (r == 0) begin
         return burst_type'($urandom);
      end else if (r < 10) begin
         return burst_type'($urandom_range(13, 400));
      end
      return burst_type'($urandom_range(1, 12));
   endfunction

   task automatic test_random_mix();
      int quanta [6];
      int arrive_pct [6];
      quanta     = '{1, 255, 0, 3, $urandom_range(4, 12), 2};
      arrive_pct = '{50, 45, 75, 50, 35, 60};
      for (int ph = 0; ph < 6; ph++) begin
         write_quantum(QUANT_W'(quanta[ph]));
         gaps_on = 1'b1;
         repeat (215) begin
            if ($urandom_range(0, 49) == 0) begin
               gaps_on = !gaps_on;
            end
            if ($urandom_range(0, 99) < arrive_pct[ph]) begin
               send_req(REQ_ARRIVAL, id_type'($urandom), draw_burst());
            end else begin
               send_tick();
            end
         end
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      req_if.valid      <= 1'b0;
      req_if.req_type   <= REQ_ARRIVAL;
      req_if.proc_id    <= '0;
      req_if.burst_time <= '0;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= '0;
      q_head      = 0;
      q_tail      = 0;
      q_count     = 0;
      slice_ticks = '0;
      tick_now    = '0;
      quantum_now = QUANTUM_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_extreme_fields();
      test_full_queue();
      test_quantum_zero();
      test_quantum_lowered();
      test_random_mix();

      drain_and_settle();
      if (err_count == 0 && pending_reports.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
